// ===== rtl/bounded_integer_set_table_top_assert.svh =====
// Assertion macros for the set table RTL.
`ifndef BOUNDED_INTEGER_SET_TABLE_TOP_ASSERT_SVH
`define BOUNDED_INTEGER_SET_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, off while reset is held.
`define BIST_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is held.
`define BIST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bist_pkg.sv =====
// Types, sizes and helpers for the bounded integer set table.
`timescale 1ns / 1ps

package bist_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int COUNT_FIELD_W = 5;

    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    typedef enum logic [1:0] {
        OP_ADD      = 2'd0,
        OP_REMOVE   = 2'd1,
        OP_CONTAINS = 2'd2,
        OP_CLEAR    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STS_OK   = 2'd0,
        STS_MISS = 2'd1,
        STS_FULL = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIND,
        ST_SHIFT,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_op                op;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic                     hit;
        t_status                  status;
        logic [COUNT_FIELD_W-1:0] count;
    } t_rsp;

    // Low bits of the entry count as carried in a result.
    function automatic logic [COUNT_FIELD_W-1:0] cnt_field(input logic [CNT_W-1:0] c);
        logic [CNT_W+COUNT_FIELD_W-1:0] ext;
        ext = (CNT_W + COUNT_FIELD_W)'(c);
        return ext[COUNT_FIELD_W-1:0];
    endfunction

endpackage

// ===== rtl/bist_core.sv =====
// Sequencer, entry memory and shared comparator of the set table.
`timescale 1ns / 1ps
`include "bounded_integer_set_table_top_assert.svh"

module bist_core import bist_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_req i_req,
    input  logic i_take,
    output logic o_idle,
    output logic o_done,
    output t_rsp o_rsp
);

    logic [31:0]        r_mem [CAPACITY];
    logic [31:0]        r_rd_data;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_idx, n_idx;
    t_op                r_op, n_op;
    logic signed [31:0] r_value, n_value;
    logic               r_hit, n_hit;
    t_status            r_status, n_status;

    logic               w_we;
    logic [IDX_W-1:0]   w_waddr;
    logic [31:0]        w_wdata;
    logic [IDX_W-1:0]   w_raddr;
    logic [CNT_W:0]     w_idx_inc;
    logic               w_last;
    logic               w_match;
    logic               w_full;
    logic               w_empty;

    assign w_idx_inc = {1'b0, r_idx} + (CNT_W + 1)'(1);
    assign w_last    = !(w_idx_inc < {1'b0, r_count});
    assign w_match   = (r_rd_data == r_value);
    assign w_full    = (r_count == CAP_C);
    assign w_empty   = (r_count == '0);
    assign w_raddr   = n_idx[IDX_W-1:0];

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    if (i_req.op == OP_CLEAR || (i_req.op == OP_ADD && w_full) || w_empty) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_FIND;
                    end
                end
            end
            ST_FIND: begin
                if (w_match) begin
                    n_state = (r_op == OP_REMOVE && !w_last) ? ST_SHIFT : ST_DONE;
                end else if (w_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_SHIFT: begin
                if (w_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and memory port control
    always_comb begin
        n_idx    = r_idx;
        n_count  = r_count;
        n_op     = r_op;
        n_value  = r_value;
        n_hit    = r_hit;
        n_status = r_status;
        w_we     = 1'b0;
        w_waddr  = r_count[IDX_W-1:0];
        w_wdata  = r_value;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_op     = i_req.op;
                    n_value  = i_req.value;
                    n_idx    = '0;
                    n_hit    = 1'b0;
                    n_status = STS_OK;
                    if (i_req.op == OP_CLEAR) begin
                        n_count = '0;
                    end else if (i_req.op == OP_ADD && w_full) begin
                        n_status = STS_FULL;
                    end else if (w_empty) begin
                        if (i_req.op == OP_ADD) begin
                            w_we    = 1'b1;
                            w_wdata = i_req.value;
                            n_count = r_count + CNT_W'(1);
                            n_hit   = 1'b1;
                        end else begin
                            n_status = STS_MISS;
                        end
                    end
                end
            end
            ST_FIND: begin
                if (w_match) begin
                    case (r_op)
                        OP_ADD:      n_status = STS_MISS;
                        OP_CONTAINS: n_hit    = 1'b1;
                        OP_REMOVE: begin
                            if (w_last) begin
                                n_count = r_count - CNT_W'(1);
                                n_hit   = 1'b1;
                            end else begin
                                n_idx = w_idx_inc[CNT_W-1:0];
                            end
                        end
                        default: n_status = STS_OK;
                    endcase
                end else if (w_last) begin
                    if (r_op == OP_ADD) begin
                        w_we    = 1'b1;
                        n_count = r_count + CNT_W'(1);
                        n_hit   = 1'b1;
                    end else begin
                        n_status = STS_MISS;
                    end
                end else begin
                    n_idx = w_idx_inc[CNT_W-1:0];
                end
            end
            ST_SHIFT: begin
                // move the entry just read down one place
                w_we    = 1'b1;
                w_waddr = r_idx[IDX_W-1:0] - IDX_W'(1);
                w_wdata = r_rd_data;
                if (w_last) begin
                    n_count = r_count - CNT_W'(1);
                    n_hit   = 1'b1;
                end else begin
                    n_idx = w_idx_inc[CNT_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    assign o_idle       = (r_state == ST_IDLE);
    assign o_done       = (r_state == ST_DONE);
    assign o_rsp.hit    = r_hit;
    assign o_rsp.status = r_status;
    assign o_rsp.count  = cnt_field(r_count);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_op     <= n_op;
        r_value  <= n_value;
        r_hit    <= n_hit;
        r_status <= n_status;
    end

    `BIST_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CAP_C, "entry count above capacity")
    `BIST_ASSERT_NOW(a_scan_in_range, r_state == ST_FIND || r_state == ST_SHIFT,
        r_idx < r_count, "scan index beyond held entries")
    `BIST_ASSERT_NOW(a_shift_on_remove, r_state == ST_SHIFT, r_op == OP_REMOVE,
        "shift outside a remove")
    `BIST_ASSERT_NOW(a_start_when_idle, i_start, r_state == ST_IDLE, "start while busy")
    `BIST_ASSERT_NEXT(a_done_holds, r_state == ST_DONE && !i_take,
        r_state == ST_DONE && $stable(r_count), "pending result changed")

endmodule

// ===== rtl/bounded_integer_set_table_top.sv =====
// Top level of the bounded integer set table: stream ports and result register.
`timescale 1ns / 1ps

// Bounded set of up to CAPACITY (16) distinct signed 32-bit integers.
// Slave channel: tuser carries the opcode (add, remove, contains, clear),
// tdata the 32-bit value. Master channel: one beat per accepted beat, with
// tuser holding hit and status, tdata the entry count after the operation.
// A single sequencer walks the stored entries with one comparator and one
// memory with a read port and a write port (one read and one write per
// cycle). Clear, add to a full set and any operation on an empty set
// register their result in the cycle after accept. Every other operation
// scans the held entries, plus the shift-down after the match on remove,
// and ends early when a lookup or a duplicate hits. The slave side is not
// ready while an operation runs.
// Stall: the result sits in an output register; the next beat is accepted
// while it waits, but that beat's result holds in the sequencer until the
// register frees up.
// Reset: synchronous, active low; empties the set and drops any pending
// result. Memory contents are not cleared, no clearing pass is needed.
module bounded_integer_set_table_top import bist_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] value
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] opcode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [4:0] count, [7:5] zero
    output logic [2:0]  o_m_axis_tuser    // [0] hit, [2:1] status
);

    t_req w_req;
    t_rsp w_rsp;
    logic w_idle;
    logic w_done;
    logic w_start;
    logic w_take;

    logic r_out_valid;
    t_rsp r_out;

    assign w_req.op    = t_op'(i_s_axis_tuser);
    assign w_req.value = i_s_axis_tdata;
    assign w_start     = i_s_axis_tvalid && w_idle;
    assign w_take      = w_done && (!r_out_valid || i_m_axis_tready);

    bist_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_req   (w_req),
        .i_take  (w_take),
        .o_idle  (w_idle),
        .o_done  (w_done),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // load a new beat whenever the core hands one over
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= w_rsp;
        end
    end

    assign o_s_axis_tready = w_idle;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out.count};
    assign o_m_axis_tuser  = {r_out.status, r_out.hit};

endmodule
